>>> rtl/fat_cluster_chain_step_macros.svh
// Assertion macros shared by the checker of the FAT cluster chain block.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef FAT_CLUSTER_CHAIN_STEP_MACROS_SVH
`define FAT_CLUSTER_CHAIN_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fat cluster chain check failed");

// The consequent must hold starting in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fat cluster chain check failed");

`endif

>>> rtl/fcc_pkg.sv
// Shared types and constants for the FAT cluster chain lookup block.
// Depends on nothing; used by the top level, the table store and the checker.
package fcc_pkg;

    // Default size of the table store in bytes.
    localparam int TABLE_BYTES_DEF = 65536;

    // Width of a byte offset into the table, wide enough for cluster * 4 + 4.
    localparam int AT_W = 35;

    typedef enum logic [1:0] {
        FAT12 = 2'd0,
        FAT16 = 2'd1,
        FAT32 = 2'd2,
        EXFAT = 2'd3
    } fat_type_t;

    typedef enum logic [1:0] {
        CFG_FAT_TYPE = 2'd0,
        CFG_SPC      = 2'd1,
        CFG_DATA_LBA = 2'd2
    } cfg_index_t;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_FOLLOW = 1'b1;

    localparam logic [31:0] MASK_FAT12 = 32'h0000_0fff;
    localparam logic [31:0] MASK_FAT16 = 32'h0000_ffff;
    localparam logic [31:0] MASK_FAT32 = 32'h0fff_ffff;
    localparam logic [31:0] MASK_EXFAT = 32'hffff_ffff;

    localparam logic [31:0] EOC_FAT12 = 32'h0000_0ff8;
    localparam logic [31:0] EOC_FAT16 = 32'h0000_fff8;
    localparam logic [31:0] EOC_FAT32 = 32'h0fff_fff8;
    localparam logic [31:0] EOC_EXFAT = 32'hffff_fff8;

endpackage

>>> rtl/fcc_table.sv
// Table store of the FAT cluster chain block: four byte-wide banks, one per
// byte lane, so four consecutive bytes at any offset are read in one access.
// Depends on fcc_pkg only through the parameter default handed down.
module fcc_table #(
    parameter int TABLE_BYTES = fcc_pkg::TABLE_BYTES_DEF
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [$clog2((TABLE_BYTES+3)/4)+1:0]   wr_addr,
    input  logic [7:0]                             wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2((TABLE_BYTES+3)/4)+1:0]   rd_addr,
    output logic [31:0]                            rd_word
);

    localparam int ROWS  = (TABLE_BYTES + 3) / 4;
    localparam int RBITS = $clog2(ROWS);

    logic [7:0] rd_q [4];
    logic [1:0] lane_reg;

    // Bank b holds every byte whose offset ends in b. A read that starts at
    // lane L takes lanes below L from the following row.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] LANE = 2'(b);

        logic [7:0]       mem [ROWS];
        logic [RBITS-1:0] rd_row;

        assign rd_row = rd_addr[RBITS+1:2]
                      + {{(RBITS-1){1'b0}}, (rd_addr[1:0] > LANE)};

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_addr[1:0] == LANE))
            begin
                mem[wr_addr[RBITS+1:2]] <= wr_data;
            end
            if (rd_en)
            begin
                rd_q[b] <= mem[rd_row];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            lane_reg <= rd_addr[1:0];
        end
    end

    // Rotate the bank outputs so byte 0 of the word is the starting byte.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            rd_word[8*i +: 8] = rd_q[2'(lane_reg + 2'(i))];
        end
    end

endmodule

>>> rtl/fat_cluster_chain_step.sv
// FAT cluster chain step: accepts one word per cycle (busy stays low); the
// result strobe done comes through the stage-1 and output registers. Throughput is
// one word per clock, set by one access of the four-bank table store and one
// 32x8 multiply per word. rst_n clears the pipeline and the configuration
// (FAT12, one sector per cluster, base sector 0); the table store is not
// cleared. The receiver cannot stall; each result shows for one cycle.
//
// Depends on fcc_pkg and fcc_table.
module fat_cluster_chain_step #(
    parameter int TABLE_BYTES = fcc_pkg::TABLE_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Command side.
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] table_address,
    input  logic [7:0]  table_byte,
    input  logic [31:0] cluster,

    // Result side.
    output logic        done,
    output logic [31:0] next_cluster,
    output logic        end_of_chain,
    output logic [31:0] cluster_sector,
    output logic        out_of_range
);

    localparam int ROWS  = (TABLE_BYTES + 3) / 4;
    localparam int RBITS = $clog2(ROWS);
    localparam int AW    = RBITS + 2;
    localparam int AT_W  = fcc_pkg::AT_W;

    localparam logic [AT_W-1:0] TABLE_END = AT_W'(TABLE_BYTES);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index past the
    // register list is dropped.
    // ------------------------------------------------------------------
    fcc_pkg::fat_type_t fat_type_reg;
    logic [7:0]         spc_reg;
    logic [31:0]        lba_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_type_reg <= fcc_pkg::FAT12;
            spc_reg      <= 8'd1;
            lba_reg      <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fcc_pkg::cfg_index_t'(cfg_index))
                fcc_pkg::CFG_FAT_TYPE: fat_type_reg <= fcc_pkg::fat_type_t'(cfg_data[1:0]);
                fcc_pkg::CFG_SPC:      spc_reg      <= cfg_data[7:0];
                fcc_pkg::CFG_DATA_LBA: lba_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: the accepting cycle. The entry offset is formed from the
    // cluster number, the four banks are addressed, and the sector product
    // is started. Nothing here depends on an earlier word, so the block
    // never needs to hold off the command side.
    // ------------------------------------------------------------------
    logic            accept;
    logic            is_follow;
    logic [AT_W-1:0] entry_at;
    logic [AT_W-1:0] entry_len;
    logic            rd_oor;
    logic [AT_W-1:0] wr_at;
    logic            wr_oor;
    logic            wr_en;
    logic [31:0]     cl_minus2;
    logic [31:0]     table_word;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_follow = (opcode == fcc_pkg::OP_FOLLOW);

    always_comb
    begin
        case (fat_type_reg)
            fcc_pkg::FAT12:
            begin
                // Packed 12-bit entries: offset is cluster * 3 / 2.
                entry_at  = {3'b000, cluster} + {4'b0000, cluster[31:1]};
                entry_len = AT_W'(2);
            end
            fcc_pkg::FAT16:
            begin
                entry_at  = {2'b00, cluster, 1'b0};
                entry_len = AT_W'(2);
            end
            default:
            begin
                entry_at  = {1'b0, cluster, 2'b00};
                entry_len = AT_W'(4);
            end
        endcase
    end

    // An entry is out of range as soon as any of its bytes lies past the end.
    assign rd_oor = (entry_at + entry_len) > TABLE_END;

    assign wr_at  = AT_W'(table_address);
    assign wr_oor = (wr_at >= TABLE_END);
    assign wr_en  = accept && !is_follow && !wr_oor;

    assign cl_minus2 = cluster - 32'd2;

    fcc_table #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_at[AW-1:0]),
        .wr_data (table_byte),
        .rd_en   (accept && is_follow),
        .rd_addr (entry_at[AW-1:0]),
        .rd_word (table_word)
    );

    // Stage 1 registers: the word's control bits travel beside the table read.
    logic               s1_valid_reg;
    logic               s1_follow_reg;
    logic               s1_oor_reg;
    logic               s1_odd_reg;
    fcc_pkg::fat_type_t s1_type_reg;
    logic [31:0]        s1_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_follow_reg <= is_follow;
            s1_oor_reg    <= is_follow ? rd_oor : wr_oor;
            s1_odd_reg    <= cluster[0];
            s1_type_reg   <= fat_type_reg;
            // Only the low 32 bits of the product are kept, so the sector
            // address wraps modulo 2^32.
            s1_prod_reg   <= 32'(cl_minus2 * {24'd0, spc_reg});
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: the table word is back from the banks. Pick the entry for the
    // table format, compare with the end-of-chain threshold, and finish the
    // sector address with the base sector.
    // ------------------------------------------------------------------
    logic [31:0] entry;
    logic        entry_eoc;
    logic [31:0] res_next;
    logic        res_eoc;
    logic [31:0] res_sector;

    always_comb
    begin
        case (s1_type_reg)
            fcc_pkg::FAT12:
            begin
                // Odd clusters own the upper 12 bits of the 16-bit word.
                entry = s1_odd_reg ? ({16'd0, table_word[15:0]} >> 4) & fcc_pkg::MASK_FAT12
                                   : table_word & fcc_pkg::MASK_FAT12;
                entry_eoc = (entry >= fcc_pkg::EOC_FAT12);
            end
            fcc_pkg::FAT16:
            begin
                entry     = table_word & fcc_pkg::MASK_FAT16;
                entry_eoc = (entry >= fcc_pkg::EOC_FAT16);
            end
            fcc_pkg::FAT32:
            begin
                entry     = table_word & fcc_pkg::MASK_FAT32;
                entry_eoc = (entry >= fcc_pkg::EOC_FAT32);
            end
            default:
            begin
                entry     = table_word & fcc_pkg::MASK_EXFAT;
                entry_eoc = (entry >= fcc_pkg::EOC_EXFAT);
            end
        endcase
    end

    always_comb
    begin
        if (!s1_follow_reg)
        begin
            // Table writes report only the range flag.
            res_next   = 32'd0;
            res_eoc    = 1'b0;
            res_sector = 32'd0;
        end
        else
        begin
            res_next   = s1_oor_reg ? 32'd0 : entry;
            res_eoc    = s1_oor_reg ? 1'b0 : entry_eoc;
            res_sector = s1_prod_reg + lba_reg;
        end
    end

    // Output registers: each result shows for exactly one cycle.
    logic        done_reg;
    logic [31:0] next_cluster_reg;
    logic        end_of_chain_reg;
    logic [31:0] cluster_sector_reg;
    logic        out_of_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            next_cluster_reg   <= res_next;
            end_of_chain_reg   <= res_eoc;
            cluster_sector_reg <= res_sector;
            out_of_range_reg   <= s1_oor_reg;
        end
    end

    assign done           = done_reg;
    assign next_cluster   = next_cluster_reg;
    assign end_of_chain   = end_of_chain_reg;
    assign cluster_sector = cluster_sector_reg;
    assign out_of_range   = out_of_range_reg;

endmodule

>>> rtl/fcc_checker.sv
// Port-level checks for the FAT cluster chain block, bound to its top level.
// Depends on fcc_pkg and fat_cluster_chain_step_macros.svh.
`include "fat_cluster_chain_step_macros.svh"

module fcc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        opcode,
    input logic        done,
    input logic [31:0] next_cluster,
    input logic        end_of_chain,
    input logic [31:0] cluster_sector,
    input logic        out_of_range
);

    // Every accepted word raises done after passing the stage-1 and output registers.
    `FCC_ASSERT_NEXT(a_result_follows, start && !busy, ##1 done)

    // A result never appears without a word accepted ahead of it through the stage-1 and output registers.
    `FCC_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, 2))

    // A table write reports nothing but the range flag.
    `FCC_ASSERT_NOW(a_write_quiet, done && ($past(opcode, 2) == fcc_pkg::OP_WRITE), next_cluster == 32'd0 && !end_of_chain && cluster_sector == 32'd0)

    // An entry past the table yields no next cluster and no end of chain.
    `FCC_ASSERT_NOW(a_oor_clean, done && out_of_range, next_cluster == 32'd0 && !end_of_chain)

    // End of chain is never flagged below the lowest threshold of any format.
    `FCC_ASSERT_NOW(a_eoc_floor, done && end_of_chain, next_cluster >= fcc_pkg::EOC_FAT12)

endmodule

bind fat_cluster_chain_step fcc_checker u_fcc_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for fat_cluster_chain_step: table loads, FAT12/16/32/exFAT
// lookups, end-of-chain thresholds, out-of-range entries and sector arithmetic.
// Depends on fcc_pkg and the fat_cluster_chain_step RTL; reads no files.
module tb;

    // The block is built with its default table size; the predictor mirrors it.
    localparam int TABLE_SIZE  = fcc_pkg::TABLE_BYTES_DEF;
    localparam int ITEM_TARGET = 1450;
    localparam int PHASE_WORDS = 120;
    localparam int STALL_LIMIT = 1000;

    // One lookup result as the block should present it.
    typedef struct packed {
        logic [31:0] next_cl;
        logic        eoc;
        logic [31:0] sector;
        logic        oor;
    } link_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [15:0] table_address;
    logic [7:0]  table_byte;
    logic [31:0] cluster;
    logic        done;
    logic [31:0] next_cluster;
    logic        end_of_chain;
    logic [31:0] cluster_sector;
    logic        out_of_range;

    // Shadow copy of the allocation table and of the configuration registers.
    // byte_known tracks which table bytes have been loaded, so that no lookup
    // ever touches a byte the block holds as undefined.
    bit [7:0]           fat_shadow [TABLE_SIZE];
    bit                 byte_known [TABLE_SIZE];
    fcc_pkg::fat_type_t cur_type;
    logic [7:0]         cur_spc;
    logic [31:0]        cur_lba;

    // Lookup results still owed by the block, oldest first.
    link_t       expected_links [$];
    link_t       head_link;
    link_t       last_follow;

    bit          gaps_on;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned follows_sent;
    int unsigned past_table;
    int unsigned eoc_seen;
    int unsigned regs_written;
    int unsigned fail_count;
    int unsigned stall_cycles;

    fat_cluster_chain_step #(
        .TABLE_BYTES(TABLE_SIZE)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .table_address(table_address),
        .table_byte(table_byte),
        .cluster(cluster),
        .done(done),
        .next_cluster(next_cluster),
        .end_of_chain(end_of_chain),
        .cluster_sector(cluster_sector),
        .out_of_range(out_of_range)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Byte offset of a cluster's entry. It is kept 64 bits wide so that huge
    // cluster numbers never wrap back into the table.
    function automatic longint unsigned entry_at(input logic [31:0] cl);
        longint unsigned c;
        c = cl;
        case (cur_type)
            fcc_pkg::FAT12: return c + (c >> 1);
            fcc_pkg::FAT16: return c * 2;
            default:        return c * 4;
        endcase
    endfunction

    // FAT12 and FAT16 entries span two bytes, FAT32 and exFAT four.
    function automatic int entry_len();
        return (cur_type == fcc_pkg::FAT12 || cur_type == fcc_pkg::FAT16) ? 2 : 4;
    endfunction

    function automatic logic [31:0] eoc_floor();
        case (cur_type)
            fcc_pkg::FAT12: return fcc_pkg::EOC_FAT12;
            fcc_pkg::FAT16: return fcc_pkg::EOC_FAT16;
            fcc_pkg::FAT32: return fcc_pkg::EOC_FAT32;
            default:        return fcc_pkg::EOC_EXFAT;
        endcase
    endfunction

    // Highest cluster whose whole entry still fits in the table.
    function automatic logic [31:0] last_cluster_in_table();
        longint unsigned c;
        c = (longint'(TABLE_SIZE) * 2) / 3 + 1;
        while (entry_at(c[31:0]) + entry_len() > TABLE_SIZE)
            c--;
        return c[31:0];
    endfunction

    // Works out the result of one accepted word and applies a table write to
    // the shadow. The sector is always given for a follow, even when the entry
    // itself lies past the end of the table.
    function automatic link_t chain_step_of(input logic op, input logic [15:0] addr,
                                            input logic [7:0] data, input logic [31:0] cl);
        link_t           r;
        longint unsigned at;
        logic [15:0]     raw16;
        logic [31:0]     raw32;
        r = '0;
        if (op == fcc_pkg::OP_WRITE)
        begin
            if (addr < TABLE_SIZE)
            begin
                fat_shadow[addr] = data;
                byte_known[addr] = 1'b1;
            end
            else
                r.oor = 1'b1;
            return r;
        end
        at = entry_at(cl);
        if (at + entry_len() > TABLE_SIZE)
            r.oor = 1'b1;
        else
        begin
            raw16 = {fat_shadow[at + 1], fat_shadow[at]};
            if (entry_len() == 4)
                raw32 = {fat_shadow[at + 3], fat_shadow[at + 2], raw16};
            else
                raw32 = {16'd0, raw16};
            case (cur_type)
                // Odd FAT12 clusters sit in the upper 12 bits of the pair.
                fcc_pkg::FAT12: r.next_cl = cl[0] ? {20'd0, raw16[15:4]} : {20'd0, raw16[11:0]};
                fcc_pkg::FAT16: r.next_cl = {16'd0, raw16};
                fcc_pkg::FAT32: r.next_cl = raw32 & fcc_pkg::MASK_FAT32;
                default:        r.next_cl = raw32;
            endcase
            r.eoc = (r.next_cl >= eoc_floor());
        end
        // Cluster two is the first data cluster; everything wraps at 2^32.
        r.sector = (cl - 32'd2) * {24'd0, cur_spc} + cur_lba;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Sends one command word. Inputs move on the falling edge; the word is
    // taken at the first rising edge with start high and busy low. When no
    // gap is drawn, start simply stays high for the next word.
    task automatic send_word(input logic op, input logic [15:0] addr,
                             input logic [7:0] data, input logic [31:0] cl);
        int    gap;
        link_t link;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        opcode        <= op;
        table_address <= addr;
        table_byte    <= data;
        cluster       <= cl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        link = chain_step_of(op, addr, data, cl);
        expected_links.push_back(link);
        words_sent++;
        if (op == fcc_pkg::OP_FOLLOW)
        begin
            last_follow = link;
            follows_sent++;
            if (link.oor)
                past_table++;
            if (link.eoc)
                eoc_seen++;
        end
    endtask

    // Stops sending and waits until every owed result has come back, so that
    // the block is idle before a register changes.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_links.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input fcc_pkg::cfg_index_t idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            fcc_pkg::CFG_FAT_TYPE: cur_type = fcc_pkg::fat_type_t'(data[1:0]);
            fcc_pkg::CFG_SPC:      cur_spc  = data[7:0];
            fcc_pkg::CFG_DATA_LBA: cur_lba  = data;
            default:               ;
        endcase
        regs_written++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Loads a whole entry. FAT12 entries share a byte with their neighbor,
    // so the neighbor's nibble is carried over from the shadow.
    task automatic set_entry(input logic [31:0] cl, input logic [31:0] raw);
        longint unsigned at;
        logic [15:0]     pair;
        logic [31:0]     bytes;
        int              i;
        at = entry_at(cl);
        if (cur_type == fcc_pkg::FAT12)
        begin
            pair = {fat_shadow[at + 1], fat_shadow[at]};
            if (cl[0])
                pair[15:4] = raw[11:0];
            else
                pair[11:0] = raw[11:0];
            bytes = {16'd0, pair};
        end
        else
            bytes = raw;
        for (i = 0; i < entry_len(); i++)
            send_word(fcc_pkg::OP_WRITE, 16'(at + i), bytes[8 * i +: 8], $urandom);
    endtask

    // Follows a cluster. Any byte of an in-range entry not yet loaded gets a
    // random value first, so the lookup never reads undefined table memory.
    task automatic follow_cluster(input logic [31:0] cl);
        longint unsigned at;
        int              i;
        at = entry_at(cl);
        if (at + entry_len() <= TABLE_SIZE)
        begin
            for (i = 0; i < entry_len(); i++)
                if (!byte_known[at + i])
                    send_word(fcc_pkg::OP_WRITE, 16'(at + i), 8'($urandom_range(0, 255)),
                              $urandom);
        end
        send_word(fcc_pkg::OP_FOLLOW, 16'($urandom_range(0, 65535)),
                  8'($urandom_range(0, 255)), cl);
    endtask

    // Entry contents: a quarter near the end-of-chain threshold, a quarter
    // pointing at another in-range cluster so chains can be walked, the rest
    // random. FAT32 gets random reserved top bits that the mask must drop.
    function automatic logic [31:0] link_value(input logic [31:0] top);
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0:       v = eoc_floor() - 32'd8 + $urandom_range(0, 15);
            1:       v = $urandom_range(2, top);
            default: v = $urandom;
        endcase
        if (cur_type == fcc_pkg::FAT32)
            v[31:28] = 4'($urandom_range(0, 15));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Table writes at both ends of the address range with extreme bytes.
    task automatic test_table_bytes();
        send_word(fcc_pkg::OP_WRITE, 16'h0000, 8'hff, 32'hffff_ffff);
        send_word(fcc_pkg::OP_WRITE, 16'hffff, 8'h00, 32'h0000_0000);
    endtask

    // Runs on the reset configuration (FAT12, one sector per cluster, base 0).
    // Covers even and odd packing, the threshold from both sides, cluster
    // zero whose sector wraps, and the boundary where a pair crosses the end.
    task automatic test_fat12_entries();
        logic [31:0] top;
        top = last_cluster_in_table();
        set_entry(32'd2, fcc_pkg::EOC_FAT12);
        set_entry(32'd3, fcc_pkg::EOC_FAT12 - 32'd1);
        follow_cluster(32'd2);
        follow_cluster(32'd3);
        follow_cluster(32'd0);
        follow_cluster(top);
        follow_cluster(top + 32'd1);
        follow_cluster(32'hffff_ffff);
    endtask

    // exFAT keeps all 32 bits. With zero sectors per cluster the sector is
    // just the base, here the largest base possible.
    task automatic test_exfat_entries();
        drain_results();
        write_register(fcc_pkg::CFG_FAT_TYPE, {30'd0, fcc_pkg::EXFAT});
        write_register(fcc_pkg::CFG_SPC, 32'd0);
        write_register(fcc_pkg::CFG_DATA_LBA, 32'hffff_ffff);
        set_entry(32'd5, fcc_pkg::EOC_EXFAT);
        follow_cluster(32'd5);
        follow_cluster(last_cluster_in_table() + 32'd1);
    endtask

    // Random phases, each under its own setting of all three registers and
    // with or without sender gaps. Most words build and walk chains; the rest
    // probe boundaries, far-out clusters and stray table writes.
    task automatic test_random_settings();
        int unsigned phase;
        int unsigned phase_end;
        int unsigned pick;
        logic [31:0] top;
        logic [31:0] cl;
        logic [31:0] word;
        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            drain_results();
            word = $urandom;
            word[1:0] = 2'(phase % 4);
            write_register(fcc_pkg::CFG_FAT_TYPE, word);
            word = $urandom;
            case (phase % 5)
                0:       word[7:0] = 8'd1;
                1:       word[7:0] = 8'd128;
                2:       word[7:0] = 8'd0;
                3:       word[7:0] = 8'd255;
                default: word[7:0] = 8'($urandom_range(1, 128));
            endcase
            write_register(fcc_pkg::CFG_SPC, word);
            case (phase % 3)
                0:       write_register(fcc_pkg::CFG_DATA_LBA, 32'd0);
                1:       write_register(fcc_pkg::CFG_DATA_LBA, 32'hffff_ffff);
                default: write_register(fcc_pkg::CFG_DATA_LBA, $urandom);
            endcase
            gaps_on = (phase % 3 != 2);
            top = last_cluster_in_table();
            last_follow = '0;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end && words_sent < ITEM_TARGET)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    cl = $urandom_range(0, top);
                    set_entry(cl, link_value(top));
                    follow_cluster(cl);
                end
                else if (pick < 70)
                begin
                    // Walk on from the last lookup while the chain stays in the table.
                    if (!last_follow.oor && !last_follow.eoc && last_follow.next_cl <= top)
                        cl = last_follow.next_cl;
                    else
                        cl = $urandom_range(2, top);
                    follow_cluster(cl);
                end
                else if (pick < 82)
                begin
                    case ($urandom_range(0, 6))
                        0:       cl = 32'd0;
                        1:       cl = 32'd1;
                        2:       cl = top;
                        3:       cl = top + 32'd1;
                        4:       cl = 32'hffff_ffff;
                        5:       cl = 32'h8000_0000 | $urandom;
                        default: cl = 32'h0001_0000 | $urandom;
                    endcase
                    follow_cluster(cl);
                end
                else if (pick < 92)
                    follow_cluster($urandom);
                else
                    send_word(fcc_pkg::OP_WRITE, 16'($urandom_range(0, 65535)),
                              8'($urandom_range(0, 255)), $urandom);
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic flag_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Each result word is on the ports for exactly one cycle and cannot be
    // held off, so it is taken at every rising edge where done is high.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_links.size() == 0)
            begin
                fail_count++;
                $display("%0t: result word with none expected, next_cluster %h",
                         $time, next_cluster);
            end
            else
            begin
                head_link = expected_links.pop_front();
                results_checked++;
                flag_field("next_cluster", head_link.next_cl, next_cluster);
                flag_field("end_of_chain", {31'd0, head_link.eoc}, {31'd0, end_of_chain});
                flag_field("cluster_sector", head_link.sector, cluster_sector);
                flag_field("out_of_range", {31'd0, head_link.oor}, {31'd0, out_of_range});
            end
        end
    end

    // Ends the run when nothing has moved on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results still owed", $time, expected_links.size());
            $display("fat_cluster_chain_step: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = fcc_pkg::CFG_FAT_TYPE;
        cfg_data      = 32'd0;
        start         = 1'b0;
        opcode        = fcc_pkg::OP_WRITE;
        table_address = 16'd0;
        table_byte    = 8'd0;
        cluster       = 32'd0;
        cur_type      = fcc_pkg::FAT12;
        cur_spc       = 8'd1;
        cur_lba       = 32'd0;
        last_follow   = '0;
        gaps_on       = 1'b1;
        words_sent      = 0;
        results_checked = 0;
        follows_sent    = 0;
        past_table      = 0;
        eoc_seen        = 0;
        regs_written    = 0;
        fail_count      = 0;
        stall_cycles    = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_table_bytes();
        test_fat12_entries();
        test_exfat_entries();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_links.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d results never arrived", $time, expected_links.size());
        end

        $display("Covered %0d words under %0d register writes: %0d lookups, %0d past the table,",
                 words_sent, regs_written, follows_sent, past_table);
        $display("%0d at end of chain; %0d results checked, %0d field mismatches.",
                 eoc_seen, results_checked, fail_count);
        if (fail_count == 0)
            $display("fat_cluster_chain_step: match");
        else
            $display("fat_cluster_chain_step: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/fcc_pkg.sv
rtl/fcc_table.sv
rtl/fat_cluster_chain_step.sv
rtl/fcc_checker.sv
tb/tb.sv
